### design/atas_pkg.sv
// Package for the ATA PIO LBA28 sequencer: result record, codes, constants.
// Used by every module in design/; no dependencies.
package atas_pkg;

	localparam int WORDS_PER_SECTOR_DEF = 256;
	localparam int DRIVE_COUNT_DEF = 2;

	localparam logic [2:0] ACT_INIT = 3'd0;
	localparam logic [2:0] ACT_READ = 3'd1;
	localparam logic [2:0] ACT_WRITE = 3'd2;
	localparam logic [2:0] ACT_QUERY = 3'd3;
	localparam logic [2:0] ACT_STAT = 3'd4;
	localparam logic [2:0] ACT_DWORD = 3'd5;
	localparam logic [2:0] ACT_HWORD = 3'd6;

	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_WR = 3'd1;
	localparam logic [2:0] OP_STAT = 3'd2;
	localparam logic [2:0] OP_DRD = 3'd3;
	localparam logic [2:0] OP_DWR = 3'd4;

	localparam logic [1:0] RES_OK = 2'd0;
	localparam logic [1:0] RES_ERR = 2'd1;
	localparam logic [1:0] RES_NOT_READY = 2'd2;
	localparam logic [1:0] RES_BAD_PARAM = 2'd3;

	localparam logic [1:0] DS_OK = 2'd0;
	localparam logic [1:0] DS_NOINIT = 2'd1;
	localparam logic [1:0] DS_NODISK = 2'd2;

	localparam logic [2:0] REG_DATA = 3'd0;
	localparam logic [2:0] REG_COUNT = 3'd2;
	localparam logic [2:0] REG_LBA_LO = 3'd3;
	localparam logic [2:0] REG_LBA_MID = 3'd4;
	localparam logic [2:0] REG_LBA_HI = 3'd5;
	localparam logic [2:0] REG_SEL = 3'd6;
	localparam logic [2:0] REG_CMD = 3'd7;

	localparam logic [7:0] SEL_BASE = 8'hE0;
	localparam logic [31:0] LBA_MAX = 32'h0FFF_FFFF;
	localparam logic [3:0] LBA_TOP_MASK = 4'hF;
	localparam logic [7:0] CMD_READ = 8'h20;
	localparam logic [7:0] CMD_WRITE = 8'h30;

	localparam logic [1:0] CFG_D0 = 2'd0;
	localparam logic [1:0] CFG_D1 = 2'd1;
	localparam logic [1:0] CFG_LIMIT = 2'd2;

	typedef struct packed {
		logic [2:0] bus_op;
		logic [2:0] reg_addr;
		logic [15:0] bus_data;
		logic [15:0] read_word;
		logic read_word_valid;
		logic done_res;
		logic [1:0] outcome;
		logic [1:0] drive_state;
		logic last;
	} res_t;

	// Classified input item handed from front to back.
	typedef struct packed {
		logic [2:0] action;
		logic drive;
		logic [31:0] lba;
		logic [7:0] sector_count;
		logic [7:0] device_status;
		logic [15:0] device_word;
		logic [15:0] host_word;
	} item_t;

	function automatic res_t res_make(logic [2:0] op, logic [2:0] addr, logic [15:0] data);
		res_t r;
		r = '0;
		r.bus_op = op;
		r.reg_addr = addr;
		r.bus_data = data;
		return r;
	endfunction

endpackage

### design/atas_front.sv
// Front end: input skid queue of two items holding accepted items.
// Depends on atas_pkg.
module atas_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input atas_pkg::item_t in_item,
	output logic item_valid,
	output atas_pkg::item_t item,
	input logic item_take
);
	import atas_pkg::*;

	item_t slot_q [2];
	logic [1:0] cnt_q;
	logic rd_q, wr_q;

	assign full = cnt_q[1];
	assign item_valid = cnt_q != 2'd0;
	assign item = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) slot_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (push && !full) wr_q <= ~wr_q;
			if (item_take && item_valid) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(item_take && item_valid);
		end
	end
endmodule

### design/atas_outq.sv
// Result queue: stores result beats until popped.
// Depends on atas_pkg.
module atas_outq #(
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input atas_pkg::res_t wr_data,
	output logic [$clog2(DEPTH+1)-1:0] count,
	output logic empty,
	input logic pop,
	output atas_pkg::res_t rd_data
);
	import atas_pkg::*;

	localparam int AW = $clog2(DEPTH);
	res_t mem_q [DEPTH];
	logic [AW-1:0] rp_q, wp_q;
	logic [$clog2(DEPTH+1)-1:0] cnt_q;

	assign count = cnt_q;
	assign empty = cnt_q == '0;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= '0;
			wp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= wp_q + 1'b1;
			if (pop && !empty) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + ($bits(cnt_q))'(wr_en) - ($bits(cnt_q))'(pop && !empty);
		end
	end
endmodule

### design/atas_back.sv
// Back end: sequencer that turns one item into up to six result beats,
// one beat per cycle while room is high. Depends on atas_pkg.
module atas_back #(
	parameter int WORDS_PER_SECTOR = atas_pkg::WORDS_PER_SECTOR_DEF,
	parameter int DRIVE_COUNT = atas_pkg::DRIVE_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic drive0_present,
	input logic drive1_present,
	input logic [31:0] poll_limit,
	input logic item_valid,
	input atas_pkg::item_t item,
	output logic item_take,
	input logic room,
	output logic res_wr,
	output atas_pkg::res_t res
);
	import atas_pkg::*;

	localparam int WW = $clog2(WORDS_PER_SECTOR + 1);
	localparam logic [4:0] PH_IDLE = 5'd0, PH_B0 = 5'd1, PH_B1 = 5'd2, PH_C1 = 5'd3,
		PH_B2 = 5'd4, PH_C2 = 5'd5, PH_B3 = 5'd6, PH_C3 = 5'd7, PH_RDATA = 5'd8,
		PH_WDATA = 5'd9, PH_FINAL = 5'd10;

	logic [4:0] phase_q, phase_n;
	logic drv_q, wr_q, bad_q;
	logic [27:0] sec_q;
	logic [7:0] left_q;
	logic [WW-1:0] words_q;
	logic [31:0] poll_q;
	logic [1:0] init_q;
	// burst of pending beats for the current item
	res_t beats [7];
	logic [2:0] nb, idx_q;
	logic busy_q;
	item_t it_q;

	logic pres, inited;
	logic [7:0] st;
	logic [7:0] selv;
	logic cw_done;
	logic [WW-1:0] words_n;
	logic [7:0] left_n;
	logic [31:0] poll_n;
	logic [1:0] init_n;
	logic drv_n, wr_n, bad_n;
	logic [27:0] sec_n;

	always_comb begin
		pres = (int'(it_q.drive) < DRIVE_COUNT) &&
			(it_q.drive ? drive1_present : drive0_present);
		inited = (int'(it_q.drive) < DRIVE_COUNT) && init_q[it_q.drive];
	end

	always_comb begin
		logic [7:0] vdrv;
		logic tmo;
		vdrv = SEL_BASE | {3'b000, drv_q, 4'b0000};
		st = it_q.device_status;
		selv = SEL_BASE | {3'b000, it_q.drive, 4'b0000};
		for (int i = 0; i < 7; i++) beats[i] = '0;
		nb = '0;
		phase_n = phase_q;
		words_n = words_q;
		left_n = left_q;
		poll_n = poll_q;
		init_n = init_q;
		drv_n = drv_q;
		wr_n = wr_q;
		bad_n = bad_q;
		sec_n = sec_q;
		cw_done = 1'b0;
		tmo = poll_q >= poll_limit;
		if (it_q.action == ACT_QUERY) begin
			beats[0] = '0;
			beats[0].drive_state = pres ? (inited ? DS_OK : DS_NOINIT) : DS_NODISK;
			nb = 3'd1;
		end else if (phase_q == PH_IDLE) begin
			if (it_q.action == ACT_INIT) begin
				nb = 3'd1;
				if (inited) beats[0] = '0;
				else if (pres) begin
					init_n[it_q.drive] = 1'b1;
					beats[0] = res_make(OP_WR, REG_SEL, {8'h00, selv});
				end else begin
					beats[0] = '0;
					beats[0].drive_state = DS_NODISK;
				end
			end else if (it_q.action == ACT_READ || it_q.action == ACT_WRITE) begin
				drv_n = it_q.drive;
				wr_n = it_q.action == ACT_WRITE;
				bad_n = (it_q.sector_count == 8'd0) || (it_q.lba > LBA_MAX);
				sec_n = it_q.lba[27:0];
				left_n = it_q.sector_count;
				words_n = '0;
				poll_n = '0;
				beats[0] = res_make(OP_WR, REG_SEL, {8'h00, selv});
				beats[1] = res_make(OP_STAT, REG_CMD, 16'h0);
				nb = 3'd2;
				phase_n = PH_B0;
			end
		end else if (it_q.action == ACT_STAT) begin
			unique case (phase_q)
				PH_B0: begin
					if (st[7] && !tmo) begin
						poll_n = poll_q + 32'd1;
						beats[0] = res_make(OP_STAT, REG_CMD, 16'h0);
						nb = 3'd1;
					end else if (bad_q) begin
						beats[0] = '0; beats[0].done_res = 1'b1;
						beats[0].outcome = RES_BAD_PARAM; nb = 3'd1; phase_n = PH_IDLE;
					end else if (!((int'(drv_q) < DRIVE_COUNT) &&
						(drv_q ? drive1_present : drive0_present) && init_q[drv_q])) begin
						beats[0] = '0; beats[0].done_res = 1'b1;
						beats[0].outcome = RES_NOT_READY; nb = 3'd1; phase_n = PH_IDLE;
					end else begin
						poll_n = '0;
						beats[0] = res_make(OP_STAT, REG_CMD, 16'h0);
						nb = 3'd1; phase_n = PH_B1;
					end
				end
				PH_B1, PH_B2, PH_B3: begin
					nb = 3'd1;
					if (st[7] && tmo) begin
						beats[0] = '0; beats[0].done_res = 1'b1;
						beats[0].outcome = RES_ERR; phase_n = PH_IDLE;
					end else if (st[7]) begin
						poll_n = poll_q + 32'd1;
						beats[0] = res_make(OP_STAT, REG_CMD, 16'h0);
					end else begin
						beats[0] = res_make(OP_STAT, REG_CMD, 16'h0);
						phase_n = phase_q + 5'd1;
					end
				end
				PH_C1: begin
					if (!st[6]) begin
						beats[0] = '0; beats[0].done_res = 1'b1;
						beats[0].outcome = RES_ERR; nb = 3'd1; phase_n = PH_IDLE;
					end else begin
						beats[0] = res_make(OP_WR, REG_SEL,
							{8'h00, vdrv | {4'h0, sec_q[27:24] & LBA_TOP_MASK}});
						beats[1] = res_make(OP_STAT, REG_CMD, 16'h0);
						nb = 3'd2; poll_n = '0; phase_n = PH_B2;
					end
				end
				PH_C2: begin
					if (!st[6]) begin
						beats[0] = '0; beats[0].done_res = 1'b1;
						beats[0].outcome = RES_ERR; nb = 3'd1; phase_n = PH_IDLE;
					end else begin
						beats[0] = res_make(OP_WR, REG_LBA_HI, {8'h00, sec_q[23:16]});
						beats[1] = res_make(OP_WR, REG_LBA_MID, {8'h00, sec_q[15:8]});
						beats[2] = res_make(OP_WR, REG_LBA_LO, {8'h00, sec_q[7:0]});
						beats[3] = res_make(OP_WR, REG_COUNT, {8'h00, left_q});
						beats[4] = res_make(OP_WR, REG_CMD,
							{8'h00, wr_q ? CMD_WRITE : CMD_READ});
						beats[5] = res_make(OP_STAT, REG_CMD, 16'h0);
						nb = 3'd6; poll_n = '0; phase_n = PH_B3;
					end
				end
				PH_C3: begin
					if (!st[3]) begin
						beats[0] = '0; beats[0].done_res = 1'b1;
						beats[0].outcome = RES_ERR; nb = 3'd1; phase_n = PH_IDLE;
					end else begin
						words_n = WW'(WORDS_PER_SECTOR);
						if (wr_q) phase_n = PH_WDATA;
						else begin
							beats[0] = res_make(OP_DRD, REG_DATA, 16'h0);
							nb = 3'd1; phase_n = PH_RDATA;
						end
					end
				end
				PH_FINAL: begin
					beats[0] = '0; beats[0].done_res = 1'b1;
					beats[0].outcome = RES_OK; nb = 3'd1; phase_n = PH_IDLE;
				end
				default: ;
			endcase
		end else if ((it_q.action == ACT_DWORD && phase_q == PH_RDATA) ||
			(it_q.action == ACT_HWORD && phase_q == PH_WDATA)) begin
			// count one word; wrap to a fresh sector unless this was the last
			words_n = (words_q != '0) ? words_q - 1'b1 : words_q;
			if (words_n == '0) begin
				left_n = (left_q != 8'd0) ? left_q - 8'd1 : left_q;
				if (left_n == 8'd0) cw_done = 1'b1;
				else words_n = WW'(WORDS_PER_SECTOR);
			end
			if (phase_q == PH_RDATA) begin
				beats[0] = res_make(cw_done ? OP_STAT : OP_DRD,
					cw_done ? REG_CMD : REG_DATA, 16'h0);
				beats[0].read_word = it_q.device_word;
				beats[0].read_word_valid = 1'b1;
				nb = 3'd1;
			end else begin
				beats[0] = res_make(OP_DWR, REG_DATA, it_q.host_word);
				beats[1] = res_make(OP_STAT, REG_CMD, 16'h0);
				nb = cw_done ? 3'd2 : 3'd1;
			end
			if (cw_done) phase_n = PH_FINAL;
		end
	end

	// Load an item, compute its beats in the next cycle, stream them one a cycle while room is high.
	logic [4:0] ph_s;
	res_t hold_q [7];
	logic [2:0] cnt_q;

	assign item_take = item_valid && !busy_q && (cnt_q == 3'd0 || (idx_q + 3'd1 == cnt_q && room));
	assign res_wr = cnt_q != 3'd0 && room;
	always_comb begin
		res = hold_q[idx_q];
		res.last = idx_q + 3'd1 == cnt_q;
	end
	assign ph_s = phase_n;

	always_ff @(posedge clk) begin
		if (item_take) it_q <= item;
		if (busy_q) for (int i = 0; i < 7; i++) hold_q[i] <= beats[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; drv_q <= 1'b0; wr_q <= 1'b0; bad_q <= 1'b0;
			sec_q <= '0; left_q <= '0; words_q <= '0; poll_q <= '0; init_q <= '0;
			busy_q <= 1'b0; idx_q <= '0; cnt_q <= '0;
		end else begin
			if (res_wr) begin
				if (idx_q + 3'd1 == cnt_q) begin
					cnt_q <= '0; idx_q <= '0;
				end else idx_q <= idx_q + 3'd1;
			end
			busy_q <= item_take;
			if (busy_q) begin
				phase_q <= ph_s; drv_q <= drv_n; wr_q <= wr_n; bad_q <= bad_n;
				sec_q <= sec_n; left_q <= left_n; words_q <= words_n; poll_q <= poll_n;
				init_q <= init_n; cnt_q <= nb; idx_q <= '0;
			end
		end
	end
endmodule

### design/ata_pio_lba28_command_sequencer_core.sv
// ATA PIO LBA28 task-file sequencer, host side, two drives.
// An accepted item is registered in the back end, its beats are computed and held, then
// streamed out; a new item can be taken in the same cycle as the current last beat is written.
// The back sequencer emits one beat per cycle into the result queue while it has room.
// Reset (arst_n low, async): sequencer idle, no drive initialized, queues empty,
// drives absent, poll limit 65535.
module ata_pio_lba28_command_sequencer_core #(
	parameter int WORDS_PER_SECTOR = atas_pkg::WORDS_PER_SECTOR_DEF,
	parameter int DRIVE_COUNT = atas_pkg::DRIVE_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [2:0] action,
	input logic drive,
	input logic [31:0] lba,
	input logic [7:0] sector_count,
	input logic [7:0] device_status,
	input logic [15:0] device_word,
	input logic [15:0] host_word,
	output logic empty,
	input logic pop,
	output logic [2:0] bus_op,
	output logic [2:0] reg_addr,
	output logic [15:0] bus_data,
	output logic [15:0] read_word,
	output logic read_word_valid,
	output logic done_res,
	output logic [1:0] outcome,
	output logic [1:0] drive_state,
	output logic last,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);
	import atas_pkg::*;

	localparam int QD = 16;

	item_t in_item, item;
	logic item_valid, item_take, res_wr, room;
	res_t res, q_out;
	logic [$clog2(QD+1)-1:0] q_cnt;
	logic d0_q, d1_q;
	logic [31:0] limit_q;

	assign cfg_ready = 1'b1;
	// Hold config registers; the user must write them only while idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d0_q <= 1'b0; d1_q <= 1'b0; limit_q <= 32'd65535;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_D0) d0_q <= cfg_data[0];
			if (cfg_index == CFG_D1) d1_q <= cfg_data[0];
			if (cfg_index == CFG_LIMIT) limit_q <= cfg_data;
		end
	end

	assign in_item = '{action: action, drive: drive, lba: lba, sector_count: sector_count,
		device_status: device_status, device_word: device_word, host_word: host_word};

	atas_front u_front (.clk, .arst_n, .push, .full, .in_item, .item_valid, .item, .item_take);

	// Write a beat only while the result queue has a free slot; hold the burst otherwise.
	assign room = int'(q_cnt) < QD;

	atas_back #(.WORDS_PER_SECTOR(WORDS_PER_SECTOR), .DRIVE_COUNT(DRIVE_COUNT)) u_back (
		.clk, .arst_n, .drive0_present(d0_q), .drive1_present(d1_q), .poll_limit(limit_q),
		.item_valid, .item, .item_take, .room, .res_wr, .res);

	atas_outq #(.DEPTH(QD)) u_outq (.clk, .arst_n, .wr_en(res_wr), .wr_data(res),
		.count(q_cnt), .empty, .pop, .rd_data(q_out));

	assign bus_op = q_out.bus_op;
	assign reg_addr = q_out.reg_addr;
	assign bus_data = q_out.bus_data;
	assign read_word = q_out.read_word;
	assign read_word_valid = q_out.read_word_valid;
	assign done_res = q_out.done_res;
	assign outcome = q_out.outcome;
	assign drive_state = q_out.drive_state;
	assign last = q_out.last;
endmodule

### test/ata_pio_lba28_command_sequencer_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the ATA PIO LBA28 command sequencer core.
// Depends on design/atas_pkg.sv and the core; predicts every result beat in place.
module ata_pio_lba28_command_sequencer_core_tb;
	import atas_pkg::*;

	localparam int WORDS_PER_SECTOR = WORDS_PER_SECTOR_DEF;
	localparam logic [2:0] ACT_UNUSED = 3'd7;
	localparam logic [7:0] ST_BSY_BIT = 8'h80;
	localparam logic [7:0] ST_DRDY_BIT = 8'h40;
	localparam logic [7:0] ST_DRQ_BIT = 8'h08;

	// Sequencer phases as the predictor tracks them; order matters (B* + 1 = C*).
	typedef enum logic [3:0] {
		S_IDLE, S_B0, S_B1, S_C1, S_B2, S_C2, S_B3, S_C3, S_RDATA, S_WDATA, S_FINAL
	} seq_phase_e;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic [2:0] action;
	logic drive;
	logic [31:0] lba;
	logic [7:0] sector_count;
	logic [7:0] device_status;
	logic [15:0] device_word;
	logic [15:0] host_word;
	logic empty;
	logic pop;
	logic [2:0] bus_op;
	logic [2:0] reg_addr;
	logic [15:0] bus_data;
	logic [15:0] read_word;
	logic read_word_valid;
	logic done_res;
	logic [1:0] outcome;
	logic [1:0] drive_state;
	logic last;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	ata_pio_lba28_command_sequencer_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.action(action),
		.drive(drive),
		.lba(lba),
		.sector_count(sector_count),
		.device_status(device_status),
		.device_word(device_word),
		.host_word(host_word),
		.empty(empty),
		.pop(pop),
		.bus_op(bus_op),
		.reg_addr(reg_addr),
		.bus_data(bus_data),
		.read_word(read_word),
		.read_word_valid(read_word_valid),
		.done_res(done_res),
		.outcome(outcome),
		.drive_state(drive_state),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predictor state: a shadow of the sequencer and its registers.
	seq_phase_e ph;
	logic act_drv;
	logic [27:0] lba_reg;
	logic wr_req;
	logic [7:0] secs_left;
	int words_left;
	logic [31:0] polls;
	logic par_bad;
	logic inited [2];
	logic present [2];
	logic [31:0] poll_lim;

	res_t beat_q[$];		// expected result beats, oldest first
	res_t got_exp;
	int errors;
	int items_sent;
	int requests_sent;
	int beats_checked;
	int hold_left;			// long receiver hold-off, counted by the pop process
	int stall_left;
	bit no_gaps;

	// Clock: 20 ns period.
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#20_000_000;
		$display("timeout with %0d beats still expected", beat_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic res_t mk_beat(logic [2:0] op, logic [2:0] addr, logic [15:0] data);
		res_t r;
		r = '0;
		r.bus_op = op;
		r.reg_addr = addr;
		r.bus_data = data;
		return r;
	endfunction

	function automatic res_t done_beat(logic [1:0] oc);
		res_t r;
		r = mk_beat(OP_NONE, REG_DATA, 16'h0);
		r.done_res = 1'b1;
		r.outcome = oc;
		return r;
	endfunction

	function automatic logic [7:0] select_byte(logic d);
		return SEL_BASE | {3'b000, d, 4'b0000};
	endfunction

	// Count one moved word; true after the last word of the request.
	function automatic bit word_moved();
		if (words_left > 0)
			words_left--;
		if (words_left != 0)
			return 1'b0;
		if (secs_left > 0)
			secs_left--;
		if (secs_left == 0)
			return 1'b1;
		words_left = WORDS_PER_SECTOR;
		return 1'b0;
	endfunction

	// Work out the result beats of one accepted item and queue them.
	function automatic void predict_item(logic [2:0] act, logic d, logic [31:0] l,
			logic [7:0] cnt, logic [7:0] st, logic [15:0] dw, logic [15:0] hw);
		res_t nb[$];
		res_t r;
		logic [1:0] ds;
		bit fin;
		if (act == ACT_QUERY) begin
			// answered in every phase
			ds = present[d] ? (inited[d] ? DS_OK : DS_NOINIT) : DS_NODISK;
			r = mk_beat(OP_NONE, REG_DATA, 16'h0);
			r.drive_state = ds;
			nb.push_back(r);
		end else if (ph == S_IDLE) begin
			if (act == ACT_INIT) begin
				if (inited[d]) begin
					nb.push_back(mk_beat(OP_NONE, REG_DATA, 16'h0));
				end else if (present[d]) begin
					inited[d] = 1'b1;
					nb.push_back(mk_beat(OP_WR, REG_SEL, {8'h00, select_byte(d)}));
				end else begin
					r = mk_beat(OP_NONE, REG_DATA, 16'h0);
					r.drive_state = DS_NODISK;
					nb.push_back(r);
				end
			end else if (act == ACT_READ || act == ACT_WRITE) begin
				act_drv = d;
				wr_req = (act == ACT_WRITE);
				par_bad = (cnt == 0) || (l > LBA_MAX);
				lba_reg = l[27:0];
				secs_left = cnt;
				words_left = 0;
				polls = 0;
				nb.push_back(mk_beat(OP_WR, REG_SEL, {8'h00, select_byte(d)}));
				nb.push_back(mk_beat(OP_STAT, REG_CMD, 16'h0));
				ph = S_B0;
			end
		end else if (act == ACT_STAT) begin
			case (ph)
				S_B0: begin
					// first busy wait: a timeout just ends the wait
					if (st[7] && polls < poll_lim) begin
						polls++;
						nb.push_back(mk_beat(OP_STAT, REG_CMD, 16'h0));
					end else if (par_bad) begin
						nb.push_back(done_beat(RES_BAD_PARAM));
						ph = S_IDLE;
					end else if (!(present[act_drv] && inited[act_drv])) begin
						nb.push_back(done_beat(RES_NOT_READY));
						ph = S_IDLE;
					end else begin
						polls = 0;
						nb.push_back(mk_beat(OP_STAT, REG_CMD, 16'h0));
						ph = S_B1;
					end
				end
				S_B1, S_B2, S_B3: begin
					if (st[7]) begin
						if (polls >= poll_lim) begin
							nb.push_back(done_beat(RES_ERR));
							ph = S_IDLE;
						end else begin
							polls++;
							nb.push_back(mk_beat(OP_STAT, REG_CMD, 16'h0));
						end
					end else begin
						nb.push_back(mk_beat(OP_STAT, REG_CMD, 16'h0));
						ph = seq_phase_e'(ph + 1);
					end
				end
				S_C1: begin
					if (!st[6]) begin
						nb.push_back(done_beat(RES_ERR));
						ph = S_IDLE;
					end else begin
						nb.push_back(mk_beat(OP_WR, REG_SEL,
							{8'h00, select_byte(act_drv) | {4'h0, lba_reg[27:24]}}));
						polls = 0;
						nb.push_back(mk_beat(OP_STAT, REG_CMD, 16'h0));
						ph = S_B2;
					end
				end
				S_C2: begin
					if (!st[6]) begin
						nb.push_back(done_beat(RES_ERR));
						ph = S_IDLE;
					end else begin
						nb.push_back(mk_beat(OP_WR, REG_LBA_HI, {8'h00, lba_reg[23:16]}));
						nb.push_back(mk_beat(OP_WR, REG_LBA_MID, {8'h00, lba_reg[15:8]}));
						nb.push_back(mk_beat(OP_WR, REG_LBA_LO, {8'h00, lba_reg[7:0]}));
						nb.push_back(mk_beat(OP_WR, REG_COUNT, {8'h00, secs_left}));
						nb.push_back(mk_beat(OP_WR, REG_CMD,
							{8'h00, wr_req ? CMD_WRITE : CMD_READ}));
						polls = 0;
						nb.push_back(mk_beat(OP_STAT, REG_CMD, 16'h0));
						ph = S_B3;
					end
				end
				S_C3: begin
					if (!st[3]) begin
						nb.push_back(done_beat(RES_ERR));
						ph = S_IDLE;
					end else begin
						words_left = WORDS_PER_SECTOR;
						if (wr_req) begin
							ph = S_WDATA;	// no beat: wait for host words
						end else begin
							nb.push_back(mk_beat(OP_DRD, REG_DATA, 16'h0));
							ph = S_RDATA;
						end
					end
				end
				S_FINAL: begin
					// final status byte is not inspected
					nb.push_back(done_beat(RES_OK));
					ph = S_IDLE;
				end
				default: ;
			endcase
		end else if (act == ACT_DWORD && ph == S_RDATA) begin
			// the last word is followed by a status read, every other one by a data read
			fin = word_moved();
			r = mk_beat(fin ? OP_STAT : OP_DRD, fin ? REG_CMD : REG_DATA, 16'h0);
			r.read_word = dw;
			r.read_word_valid = 1'b1;
			nb.push_back(r);
			if (fin)
				ph = S_FINAL;
		end else if (act == ACT_HWORD && ph == S_WDATA) begin
			nb.push_back(mk_beat(OP_DWR, REG_DATA, hw));
			if (word_moved()) begin
				nb.push_back(mk_beat(OP_STAT, REG_CMD, 16'h0));
				ph = S_FINAL;
			end
		end
		if (nb.size() > 0)
			nb[nb.size() - 1].last = 1'b1;
		foreach (nb[i])
			beat_q.push_back(nb[i]);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
	endtask

	// Check each accepted result beat against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (beat_q.size() == 0) begin
				report_mismatch("beat with nothing expected", 32'(bus_op), 32'd0);
			end else begin
				got_exp = beat_q.pop_front();
				beats_checked++;
				if (bus_op !== got_exp.bus_op)
					report_mismatch("bus_op", 32'(bus_op), 32'(got_exp.bus_op));
				if (reg_addr !== got_exp.reg_addr)
					report_mismatch("reg_addr", 32'(reg_addr), 32'(got_exp.reg_addr));
				if (bus_data !== got_exp.bus_data)
					report_mismatch("bus_data", 32'(bus_data), 32'(got_exp.bus_data));
				if (read_word !== got_exp.read_word)
					report_mismatch("read_word", 32'(read_word), 32'(got_exp.read_word));
				if (read_word_valid !== got_exp.read_word_valid)
					report_mismatch("read_word_valid", 32'(read_word_valid),
						32'(got_exp.read_word_valid));
				if (done_res !== got_exp.done_res)
					report_mismatch("done_res", 32'(done_res), 32'(got_exp.done_res));
				if (outcome !== got_exp.outcome)
					report_mismatch("outcome", 32'(outcome), 32'(got_exp.outcome));
				if (drive_state !== got_exp.drive_state)
					report_mismatch("drive_state", 32'(drive_state),
						32'(got_exp.drive_state));
				if (last !== got_exp.last)
					report_mismatch("last", 32'(last), 32'(got_exp.last));
			end
		end
	end

	// Drive pop: random stalls, mostly short, and the long hold-off on request.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			pop <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (stall_left > 0) begin
			pop <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			pop <= 1'b1;
			if (!no_gaps && $urandom_range(0, 9) < 2)
				stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
					: $urandom_range(10, 40);
		end
	end

	function automatic int pick_gap();
		if (no_gaps || $urandom_range(0, 9) < 6)
			return 0;
		return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
	endfunction

	// Send one input beat. Enter and leave at a falling edge; push stays high
	// on exit so back-to-back beats follow without a gap.
	task automatic send_item(logic [2:0] act, logic d, logic [31:0] l, logic [7:0] cnt,
			logic [7:0] st, logic [15:0] dw, logic [15:0] hw);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		action <= act;
		drive <= d;
		lba <= l;
		sector_count <= cnt;
		device_status <= st;
		device_word <= dw;
		host_word <= hw;
		push <= 1'b1;
		do @(posedge clk); while (full);
		predict_item(act, d, l, cnt, st, dw, hw);
		items_sent++;
		if (act == ACT_READ || act == ACT_WRITE)
			requests_sent++;
		@(negedge clk);
	endtask

	task automatic send_random(logic [2:0] act);
		send_item(act, 1'($urandom), $urandom, 8'($urandom), 8'($urandom),
			16'($urandom), 16'($urandom));
	endtask

	// Answer a status read with the given byte; the other fields are noise.
	task automatic send_status(logic [7:0] st);
		send_item(ACT_STAT, 1'($urandom), $urandom, 8'($urandom), st,
			16'($urandom), 16'($urandom));
	endtask

	// Drop push, let every expected beat arrive, then let in-flight items settle.
	task automatic drain();
		push <= 1'b0;
		while (beat_q.size() > 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		drain();
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_D0: present[0] = val[0];
			CFG_D1: present[1] = val[0];
			CFG_LIMIT: poll_lim = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Walk one request through the task-file sequence, answering each phase.
	// deep lets it reach the data phase; otherwise DRQ is withheld at the end.
	task automatic run_request(logic wr, logic d, logic [31:0] l, logic [7:0] cnt,
			bit deep, int busy_pct, int err_pct);
		logic [7:0] st;
		int guard;
		send_item(wr ? ACT_WRITE : ACT_READ, d, l, cnt, 8'($urandom), 16'($urandom),
			16'($urandom));
		guard = 0;
		while (ph != S_IDLE && guard < 2000) begin
			guard++;
			st = 8'($urandom);
			if ($urandom_range(0, 99) < 3) begin
				// stray beat: wrong-phase actions, queries, nested requests
				send_random(3'($urandom_range(0, 7)));
			end else begin
				case (ph)
					S_B0, S_B1, S_B2, S_B3: begin
						st[7] = ($urandom_range(0, 99) < busy_pct);
						send_status(st);
					end
					S_C1, S_C2: begin
						st[6] = ($urandom_range(0, 99) >= err_pct);
						send_status(st);
					end
					S_C3: begin
						st[3] = deep && ($urandom_range(0, 99) >= err_pct);
						send_status(st);
					end
					S_RDATA: send_random(ACT_DWORD);
					S_WDATA: send_random(ACT_HWORD);
					default: send_random(ACT_STAT);
				endcase
			end
		end
	endtask

	// No drives configured: queries and init answer no disk; idle answers are dropped.
	task automatic test_absent_drives();
		send_random(ACT_QUERY);
		send_item(ACT_INIT, 1'b0, '1, '1, '1, '1, '1);
		send_item(ACT_INIT, 1'b1, '0, '0, '0, '0, '0);
		send_random(ACT_STAT);
		send_random(ACT_DWORD);
		send_random(ACT_HWORD);
		send_random(ACT_UNUSED);
		// request on an absent drive ends not ready after the first wait
		send_item(ACT_READ, 1'b0, 32'h0000_0001, 8'd1, '0, '0, '0);
		send_item(ACT_STAT, 1'b0, '0, '0, 8'h00, '0, '0);
	endtask

	// Presence on both drives: not initialized, init, then init again.
	task automatic test_init();
		write_reg(CFG_D0, 32'd1);
		write_reg(CFG_D1, 32'd1);
		send_item(ACT_QUERY, 1'b1, '0, '0, '0, '0, '0);
		send_item(ACT_INIT, 1'b0, '0, '0, '0, '0, '0);
		send_item(ACT_INIT, 1'b0, '0, '0, '0, '0, '0);
		send_item(ACT_QUERY, 1'b0, '0, '0, '0, '0, '0);
	endtask

	// Zero count and out-of-range LBA give a parameter error; drive 1 not ready.
	task automatic test_param_checks();
		run_request(1'b0, 1'b0, 32'h0000_0010, 8'd0, 1'b0, 0, 0);
		run_request(1'b1, 1'b0, 32'hFFFF_FFFF, 8'd255, 1'b0, 0, 0);
		run_request(1'b0, 1'b1, LBA_MAX, 8'd1, 1'b0, 0, 0);
	endtask

	// Poll limit zero: busy on the first wait is ignored, busy later times out.
	task automatic test_poll_timeouts();
		write_reg(CFG_LIMIT, 32'd0);
		send_item(ACT_READ, 1'b0, 32'h0123_4567, 8'd3, '0, '0, '0);
		send_item(ACT_STAT, 1'b0, '0, '0, ST_BSY_BIT, '0, '0);
		send_item(ACT_STAT, 1'b0, '0, '0, ST_BSY_BIT | ST_DRDY_BIT, '0, '0);
		write_reg(CFG_LIMIT, 32'd1);
		run_request(1'b1, 1'b0, 32'h0000_00FF, 8'd1, 1'b0, 60, 20);
		write_reg(CFG_LIMIT, 32'hFFFF_FFFF);
	endtask

	// Whole transfer: one-sector read at the top LBA, through the final status.
	task automatic test_full_transfers();
		run_request(1'b0, 1'b0, LBA_MAX, 8'd1, 1'b1, 0, 0);
		send_item(ACT_INIT, 1'b1, '0, '0, '0, '0, '0);
	endtask

	// Presence withdrawn after init: query and request both report no disk / not ready.
	task automatic test_presence_cleared();
		write_reg(CFG_D0, 32'd0);
		send_item(ACT_QUERY, 1'b0, '0, '0, '0, '0, '0);
		run_request(1'b0, 1'b0, 32'h0000_0002, 8'd4, 1'b0, 0, 0);
		write_reg(CFG_D0, 32'd1);
	endtask

	// Hold pop off for a long stretch while queries keep coming, so the core fills.
	task automatic test_backpressure();
		drain();
		no_gaps = 1'b1;
		hold_left = 400;
		repeat (30)
			send_random(ACT_QUERY);
		no_gaps = 1'b0;
		drain();
	endtask

	// Random requests under several register settings; walks stop short of data.
	task automatic test_random();
		int start_items;
		int roll;
		logic [31:0] l;
		logic [7:0] cnt;
		start_items = items_sent;
		for (int k = 0; k < 6; k++) begin
			write_reg(CFG_D0, 32'((k == 0) || ($urandom_range(0, 3) != 0)));
			write_reg(CFG_D1, 32'((k == 0) || ($urandom_range(0, 3) != 0)));
			case (k)
				0: write_reg(CFG_LIMIT, 32'd65535);
				1: write_reg(CFG_LIMIT, 32'd0);
				2: write_reg(CFG_LIMIT, 32'hFFFF_FFFF);
				default: write_reg(CFG_LIMIT, $urandom_range(1, 4));
			endcase
			no_gaps = (k % 2 == 1);
			send_random(ACT_INIT);
			send_random(ACT_INIT);
			while (items_sent - start_items < 8 * (k + 1)) begin
				roll = $urandom_range(0, 99);
				if (roll < 8) begin
					send_random(ACT_INIT);
				end else if (roll < 16) begin
					send_random(ACT_QUERY);
				end else if (roll < 20) begin
					send_random(3'($urandom_range(4, 7)));
				end else begin
					l = $urandom;
					if ($urandom_range(0, 9) != 0)
						l = l & LBA_MAX;
					cnt = 8'($urandom);
					if ($urandom_range(0, 19) == 0)
						cnt = 8'd0;
					run_request(1'($urandom), 1'($urandom), l, cnt, 1'b0,
						$urandom_range(0, 40), $urandom_range(0, 25));
				end
			end
		end
		no_gaps = 1'b0;
	endtask

	// Write on drive 0 up to DRQ, then a few host words; the run ends mid-sector.
	task automatic test_write_words();
		write_reg(CFG_D0, 32'd1);
		write_reg(CFG_LIMIT, 32'd65535);
		send_item(ACT_INIT, 1'b0, '0, '0, '0, '0, '0);
		send_item(ACT_WRITE, 1'b0, 32'h0ABC_DEF1, 8'd2, '0, '0, '0);
		send_status(ST_BSY_BIT);
		send_status(8'h00);
		send_status(8'h00);
		send_status(ST_DRDY_BIT);
		send_status(8'h00);
		send_status(ST_DRDY_BIT);
		send_status(8'h00);
		send_status(ST_DRQ_BIT);
		repeat (16)
			send_random(ACT_HWORD);
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		action = ACT_INIT;
		drive = 1'b0;
		lba = '0;
		sector_count = '0;
		device_status = '0;
		device_word = '0;
		host_word = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_D0;
		cfg_data = '0;
		errors = 0;
		items_sent = 0;
		requests_sent = 0;
		beats_checked = 0;
		hold_left = 0;
		stall_left = 0;
		no_gaps = 1'b0;
		// predictor reset state
		ph = S_IDLE;
		act_drv = 1'b0;
		lba_reg = '0;
		wr_req = 1'b0;
		secs_left = '0;
		words_left = 0;
		polls = '0;
		par_bad = 1'b0;
		inited[0] = 1'b0;
		inited[1] = 1'b0;
		present[0] = 1'b0;
		present[1] = 1'b0;
		poll_lim = 32'd65535;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_absent_drives();
		test_init();
		test_param_checks();
		test_poll_timeouts();
		test_full_transfers();
		test_presence_cleared();
		test_backpressure();
		test_random();
		test_write_words();
		drain();

		$display("run covered %0d input beats, %0d read/write requests, %0d result beats",
			items_sent, requests_sent, beats_checked);
		$display("settings included absent drives, poll limits 0, 1-4, 65535 and all ones");
		if (errors == 0 && beat_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d beats left over", errors, beat_q.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

### filelist.f
design/atas_pkg.sv
design/atas_front.sv
design/atas_outq.sv
design/atas_back.sv
design/ata_pio_lba28_command_sequencer_core.sv
test/ata_pio_lba28_command_sequencer_core_tb.sv
